// ----- rtl/pfa_pkg.sv -----
`timescale 1ns / 1ps
// Package for the packet fragment assembler: shared constants, types and the
// byte swap function. No dependencies.
package pfa_pkg;

  localparam int WORD_W       = 32;
  localparam int FILL_W       = 6;   // fill count, holds up to 63 words
  localparam int HEADER_WORDS = 7;
  localparam int EMIT_W       = 7;   // counts header plus payload words
  localparam int HEADER_BASE  = 28;  // header size in bytes

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_END_MARKER     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EQUIPMENT_TYPE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EQUIPMENT_ID   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_SIZE   = 2'd3;

  // configuration reset values
  localparam logic [WORD_W-1:0] RST_END_MARKER     = 32'hFAFA_FAFA;
  localparam logic [WORD_W-1:0] RST_EQUIPMENT_TYPE = 32'd23;
  localparam logic [WORD_W-1:0] RST_EQUIPMENT_ID   = 32'd2;
  localparam logic [WORD_W-1:0] RST_ELEMENT_SIZE   = 32'd4;

  // operation codes carried through the queue
  localparam logic OP_STORE = 1'b0;
  localparam logic OP_CLOSE = 1'b1;

  // command queue geometry
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  typedef struct packed {
    logic [WORD_W-1:0] end_marker;
    logic [WORD_W-1:0] equipment_type;
    logic [WORD_W-1:0] equipment_id;
    logic [WORD_W-1:0] element_size;
  } cfg_t;

  typedef struct packed {
    logic              op;
    logic              seq_err;
    logic [WORD_W-1:0] word;
  } q_item_t;

  typedef struct packed {
    logic              emitting;
    logic [FILL_W-1:0] fill;
  } back_stat_t;

  function automatic logic [WORD_W-1:0] swap_bytes(input logic [WORD_W-1:0] w);
    swap_bytes = {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

endpackage

// ----- rtl/pfa_if.sv -----
`timescale 1ns / 1ps
// Channel interfaces for the packet fragment assembler: input word channel
// and output event channel. No dependencies.
interface pfa_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] word;
  logic        packet_start;
  logic        packet_end;

  modport source(output valid, word, packet_start, packet_end, input ready);
  modport sink(input valid, word, packet_start, packet_end, output ready);
endinterface

interface pfa_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_word;
  logic [31:0] event_number;
  logic [31:0] equipment_tag;
  logic        sequence_error;
  logic        overflowed;
  logic        last_of_event;

  modport source(output valid, out_word, event_number, equipment_tag,
                 sequence_error, overflowed, last_of_event, input ready);
  modport sink(input valid, out_word, event_number, equipment_tag,
               sequence_error, overflowed, last_of_event, output ready);
endinterface

// ----- rtl/pfa_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts packet words, checks sequence counts and classifies each
// item as store, close or ignore. Uses pfa_pkg and pfa_in_if.
module pfa_front (
  input  logic              clk,
  input  logic              rst,
  pfa_in_if.sink            in_ch,
  input  pfa_pkg::cfg_t     cfg,
  input  logic              q_full,
  output logic              q_push,
  output pfa_pkg::q_item_t  q_item
);

  logic [pfa_pkg::WORD_W-1:0] expected_sequence;
  logic                       accept;
  logic                       single;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;
  assign single      = in_ch.packet_start && in_ch.packet_end;

  // classify: one-word packets close or vanish, everything else is stored
  always_comb begin
    q_item.word    = in_ch.word;
    q_item.op      = single ? pfa_pkg::OP_CLOSE : pfa_pkg::OP_STORE;
    q_item.seq_err = in_ch.packet_start && !in_ch.packet_end &&
                     (in_ch.word != expected_sequence);
    q_push         = accept && (!single || (in_ch.word == cfg.end_marker));
  end

  // sequence count steps on each packet's first word, clears on close
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_sequence <= '0;
    end else if (accept) begin
      if (single) begin
        if (in_ch.word == cfg.end_marker) begin
          expected_sequence <= '0;
        end
      end else if (in_ch.packet_start) begin
        expected_sequence <= expected_sequence + 1'b1;
      end
    end
  end

endmodule

// ----- rtl/pfa_queue.sv -----
`timescale 1ns / 1ps
// Short command queue between front and back end.
// Uses pfa_pkg for the item type and depth.
module pfa_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  pfa_pkg::q_item_t  push_item,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output pfa_pkg::q_item_t  head
);

  pfa_pkg::q_item_t              entries [pfa_pkg::QUEUE_DEPTH];
  logic [pfa_pkg::QPTR_W-1:0]    wr_ptr;
  logic [pfa_pkg::QPTR_W-1:0]    rd_ptr;
  logic [pfa_pkg::QPTR_W:0]      count;
  logic                          do_push;
  logic                          do_pop;

  assign full      = (count == (pfa_pkg::QPTR_W + 1)'(pfa_pkg::QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/pfa_back.sv -----
`timescale 1ns / 1ps
// Back end: stores payload words, keeps event state and emits the header and
// byte-swapped payload of a closed event. Uses pfa_pkg and pfa_out_if.
module pfa_back #(
  parameter int STORE_WORDS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  pfa_pkg::cfg_t       cfg,
  input  logic                q_valid,
  input  pfa_pkg::q_item_t    q_head,
  output logic                q_pop,
  pfa_out_if.source           out_ch,
  output pfa_pkg::back_stat_t stat
);

  localparam int IDX_W = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
  localparam logic [pfa_pkg::FILL_W-1:0] FILL_MAX = pfa_pkg::FILL_W'(STORE_WORDS);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(STORE_WORDS - 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic [pfa_pkg::WORD_W-1:0] mem [STORE_WORDS];
  logic                       state;
  logic [pfa_pkg::FILL_W-1:0] fill;
  logic                       error_seen;
  logic                       overflow_seen;
  logic [pfa_pkg::WORD_W-1:0] event_counter;
  logic [pfa_pkg::EMIT_W-1:0] k;
  logic [IDX_W-1:0]           rd_addr;
  logic [IDX_W-1:0]           rd_addr_next;
  logic [pfa_pkg::WORD_W-1:0] rd_data;

  logic                       out_valid;
  logic [pfa_pkg::WORD_W-1:0] out_word;
  logic [pfa_pkg::WORD_W-1:0] out_event;
  logic [pfa_pkg::WORD_W-1:0] out_tag;
  logic                       out_err;
  logic                       out_ovf;
  logic                       out_last;

  logic                       out_load;
  logic [pfa_pkg::EMIT_W-1:0] total;
  logic                       is_last;
  logic [pfa_pkg::WORD_W-1:0] emit_word;
  logic                       store_ok;

  assign q_pop    = (state == ST_IDLE);
  assign out_load = (state == ST_EMIT) && (!out_valid || out_ch.ready);
  assign total    = pfa_pkg::EMIT_W'(pfa_pkg::HEADER_WORDS) + pfa_pkg::EMIT_W'(fill);
  assign is_last  = ((k + 1'b1) == total);
  assign store_ok = (fill < FILL_MAX);

  assign stat.emitting = (state == ST_EMIT);
  assign stat.fill     = fill;

  // select the word at emission position k
  always_comb begin
    case (k)
      7'd0:    emit_word = {24'd0, fill, 2'b00} + pfa_pkg::WORD_W'(pfa_pkg::HEADER_BASE);
      7'd1:    emit_word = cfg.equipment_type;
      7'd2:    emit_word = cfg.equipment_id;
      7'd3:    emit_word = '0;
      7'd4:    emit_word = '0;
      7'd5:    emit_word = '0;
      7'd6:    emit_word = cfg.element_size;
      default: emit_word = pfa_pkg::swap_bytes(rd_data);
    endcase
  end

  // read address runs one payload word ahead of the output register
  always_comb begin
    if (state != ST_EMIT) begin
      rd_addr_next = '0;
    end else if (out_load && (k >= pfa_pkg::EMIT_W'(pfa_pkg::HEADER_WORDS))) begin
      rd_addr_next = (rd_addr == IDX_LAST) ? '0 : rd_addr + 1'b1;
    end else begin
      rd_addr_next = rd_addr;
    end
  end

  // payload store
  always_ff @(posedge clk) begin
    if (q_pop && q_valid && (q_head.op == pfa_pkg::OP_STORE) && store_ok) begin
      mem[fill[IDX_W-1:0]] <= q_head.word;
    end
    rd_data <= mem[rd_addr_next];
  end

  // event state and sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      fill          <= '0;
      error_seen    <= 1'b0;
      overflow_seen <= 1'b0;
      event_counter <= '0;
      k             <= '0;
      rd_addr       <= '0;
    end else begin
      rd_addr <= rd_addr_next;
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            if (q_head.op == pfa_pkg::OP_CLOSE) begin
              event_counter <= event_counter + 1'b1;
              k             <= '0;
              state         <= ST_EMIT;
            end else begin
              error_seen <= error_seen | q_head.seq_err;
              if (store_ok) begin
                fill <= fill + 1'b1;
              end else begin
                overflow_seen <= 1'b1;
              end
            end
          end
        end
        ST_EMIT: begin
          if (out_load) begin
            k <= k + 1'b1;
            if (is_last) begin
              fill       <= '0;
              error_seen <= 1'b0;
              state      <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_word  <= emit_word;
      out_event <= event_counter;
      out_tag   <= cfg.equipment_id;
      out_err   <= error_seen;
      out_ovf   <= overflow_seen;
      out_last  <= is_last;
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.out_word       = out_word;
  assign out_ch.event_number   = out_event;
  assign out_ch.equipment_tag  = out_tag;
  assign out_ch.sequence_error = out_err;
  assign out_ch.overflowed     = out_ovf;
  assign out_ch.last_of_event  = out_last;

endmodule

// ----- rtl/packet_fragment_assembler_unit.sv -----
`timescale 1ns / 1ps
// Top level of the packet fragment assembler: configuration registers, front
// end, command queue and back end. Uses pfa_pkg, pfa_if, pfa_front,
// pfa_queue and pfa_back.
//
// Usage:
//   in_ch carries packet words with start and end marks; an item is taken
//   when valid and ready are high at a clock edge. Data words are taken one
//   per cycle while the command queue has room.
//   A one-word packet equal to end_marker closes the event: out_ch then
//   delivers 7 header words and the stored payload words, byte-swapped, one
//   per cycle while out_ch is ready, last_of_event high on the final one.
//   The back end takes no new command until the last word is loaded; the
//   close command passes the queue, the back-end state and the output
//   register before the first header word appears. Input keeps flowing
//   into the 4-entry queue meanwhile and stalls once the queue fills.
//   A stall on out_ch holds the output register and the sequencer; nothing
//   is lost. Configuration is written through cfg_we, cfg_index, cfg_data.
//   Reset clears counters, flags and the queue; configuration returns to
//   its defaults. The payload store needs no clearing.
module packet_fragment_assembler_unit #(
  parameter int STORE_WORDS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [pfa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pfa_pkg::WORD_W-1:0]      cfg_data,
  pfa_in_if.sink                          in_ch,
  pfa_out_if.source                       out_ch
);

  pfa_pkg::cfg_t       cfg;
  logic                q_push;
  pfa_pkg::q_item_t    q_item;
  logic                q_full;
  logic                q_pop;
  logic                q_valid;
  pfa_pkg::q_item_t    q_head;
  pfa_pkg::back_stat_t stat;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.end_marker     <= pfa_pkg::RST_END_MARKER;
      cfg.equipment_type <= pfa_pkg::RST_EQUIPMENT_TYPE;
      cfg.equipment_id   <= pfa_pkg::RST_EQUIPMENT_ID;
      cfg.element_size   <= pfa_pkg::RST_ELEMENT_SIZE;
    end else if (cfg_we) begin
      case (cfg_index)
        pfa_pkg::REG_END_MARKER:     cfg.end_marker     <= cfg_data;
        pfa_pkg::REG_EQUIPMENT_TYPE: cfg.equipment_type <= cfg_data;
        pfa_pkg::REG_EQUIPMENT_ID:   cfg.equipment_id   <= cfg_data;
        pfa_pkg::REG_ELEMENT_SIZE:   cfg.element_size   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  pfa_front u_front (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .cfg    (cfg),
    .q_full (q_full),
    .q_push (q_push),
    .q_item (q_item)
  );

  pfa_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  pfa_back #(
    .STORE_WORDS (STORE_WORDS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch),
    .stat    (stat)
  );

  // fill count never passes the store depth
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    stat.fill <= pfa_pkg::FILL_W'(STORE_WORDS))
    else $error("fill count beyond store depth");

  // the front end never pushes into a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_full))
    else $error("push into full command queue");

  // a taken end marker leaves a command waiting in the queue
  a_close_queued: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready && in_ch.packet_start && in_ch.packet_end &&
     (in_ch.word == cfg.end_marker)) |=> q_valid)
    else $error("close command not queued");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking bench for packet_fragment_assembler_unit: directed packets,
// then random events under four idle patterns, checked by an internal model.
// Depends on pfa_pkg, pfa_if and the RTL of the unit.
module testbench;

  localparam int STORE_WORDS    = 32;
  localparam int DRAIN_CYCLES   = 16;
  localparam int TIMEOUT_CYCLES = 200000;
  localparam int PHASE_ITEMS    = 60;
  localparam int DIR_ROWS       = 19;
  localparam logic [31:0] MK    = pfa_pkg::RST_END_MARKER;

  // one input item plus optional hand-typed checks for a closing word
  typedef struct packed {
    logic [31:0] word;
    logic        sop;
    logic        eop;
    logic        typed;
    logic [31:0] hdr_size;
    logic        seq_err;
    logic [31:0] evt_num;
  } stim_row_t;

  // one word of an emitted event
  typedef struct packed {
    logic [31:0] out_word;
    logic [31:0] event_number;
    logic [31:0] equipment_tag;
    logic        seq_err;
    logic        ovf;
    logic        last;
  } event_word_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [pfa_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_data;

  pfa_in_if  in_ch();
  pfa_out_if out_ch();

  packet_fragment_assembler_unit #(.STORE_WORDS(STORE_WORDS)) DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  // assembler state kept by the bench
  logic [31:0] close_word = pfa_pkg::RST_END_MARKER;
  logic [31:0] type_word  = pfa_pkg::RST_EQUIPMENT_TYPE;
  logic [31:0] id_word    = pfa_pkg::RST_EQUIPMENT_ID;
  logic [31:0] elem_word  = pfa_pkg::RST_ELEMENT_SIZE;
  logic [31:0] stored [STORE_WORDS];
  int          fill_count = 0;
  logic [31:0] seq_count = '0;
  logic        seq_error = 1'b0;
  logic        store_overflow = 1'b0;
  logic [31:0] event_count = '0;

  event_word_t words_due[$];
  int mismatches = 0;
  int items_sent = 0;
  int words_checked = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // directed packets; expected header size, error and event typed where obvious
  stim_row_t directed_rows [DIR_ROWS] = '{
    '{MK,           1'b1, 1'b1, 1'b1, 32'd28, 1'b0, 32'd1},  // close right after reset
    '{32'h00000000, 1'b1, 1'b1, 1'b0, 32'd0,  1'b0, 32'd0},  // one-word, not marker
    '{32'hFFFFFFFF, 1'b1, 1'b1, 1'b0, 32'd0,  1'b0, 32'd0},
    '{32'h00000000, 1'b1, 1'b0, 1'b0, 32'd0,  1'b0, 32'd0},  // in-order packet
    '{32'hFFFFFFFF, 1'b0, 1'b0, 1'b0, 32'd0,  1'b0, 32'd0},
    '{32'h12345678, 1'b0, 1'b1, 1'b0, 32'd0,  1'b0, 32'd0},
    '{32'h00000001, 1'b1, 1'b0, 1'b0, 32'd0,  1'b0, 32'd0},
    '{32'h80000000, 1'b0, 1'b1, 1'b0, 32'd0,  1'b0, 32'd0},
    '{MK,           1'b1, 1'b1, 1'b1, 32'd48, 1'b0, 32'd2},
    '{32'hFFFFFFFF, 1'b1, 1'b0, 1'b0, 32'd0,  1'b0, 32'd0},  // out-of-order start
    '{32'hA5A5A5A5, 1'b0, 1'b1, 1'b0, 32'd0,  1'b0, 32'd0},
    '{32'h5A5A5A5A, 1'b0, 1'b0, 1'b0, 32'd0,  1'b0, 32'd0},  // stray continuation
    '{32'h00000001, 1'b0, 1'b1, 1'b0, 32'd0,  1'b0, 32'd0},
    '{32'h00000001, 1'b1, 1'b0, 1'b0, 32'd0,  1'b0, 32'd0},  // count kept stepping
    '{32'h00000000, 1'b0, 1'b1, 1'b0, 32'd0,  1'b0, 32'd0},
    '{MK,           1'b1, 1'b1, 1'b1, 32'd52, 1'b1, 32'd3},
    '{32'h00000000, 1'b1, 1'b0, 1'b0, 32'd0,  1'b0, 32'd0},
    '{MK,           1'b0, 1'b1, 1'b0, 32'd0,  1'b0, 32'd0},  // marker inside a packet
    '{MK,           1'b1, 1'b1, 1'b1, 32'd36, 1'b0, 32'd4}
  };

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (TIMEOUT_CYCLES) @(posedge clk);
    $display("CHECK FAILED");
    $finish;
  end

  // receiver: ready toggles at falling edges
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %h want %h (word %0d)", name, got, want,
                                words_checked));
  endtask

  // advance the model by one accepted item, queue any event words it emits
  task automatic assemble_word(input stim_row_t row);
    logic [31:0] hdr [pfa_pkg::HEADER_WORDS];
    logic [31:0] p;
    event_word_t ew;
    int k;
    int total;
    if (row.sop && row.eop) begin
      if (row.word == close_word) begin
        event_count++;
        hdr[0] = 32'(fill_count * 4 + pfa_pkg::HEADER_BASE);
        hdr[1] = type_word;
        hdr[2] = id_word;
        hdr[3] = '0;
        hdr[4] = '0;
        hdr[5] = '0;
        hdr[6] = elem_word;
        total = pfa_pkg::HEADER_WORDS + fill_count;
        for (k = 0; k < total; k++) begin
          if (k < pfa_pkg::HEADER_WORDS) begin
            ew.out_word = hdr[k];
          end else begin
            p = stored[k - pfa_pkg::HEADER_WORDS];
            ew.out_word = {p[7:0], p[15:8], p[23:16], p[31:24]};
          end
          if (k == 0 && row.typed) ew.out_word = row.hdr_size;
          ew.event_number  = row.typed ? row.evt_num : event_count;
          ew.equipment_tag = id_word;
          ew.seq_err       = row.typed ? row.seq_err : seq_error;
          ew.ovf           = store_overflow;
          ew.last          = (k == total - 1);
          words_due.push_back(ew);
        end
        fill_count = 0;
        seq_count  = '0;
        seq_error  = 1'b0;
      end
    end else begin
      if (row.sop) begin
        if (row.word != seq_count) seq_error = 1'b1;
        seq_count = seq_count + 1;
      end
      if (fill_count < STORE_WORDS) begin
        stored[fill_count] = row.word;
        fill_count++;
      end else begin
        store_overflow = 1'b1;
      end
    end
  endtask

  function automatic stim_row_t mk_row(input logic [31:0] w, input logic s,
                                       input logic e);
    stim_row_t r;
    r = '0;
    r.word = w;
    r.sop  = s;
    r.eop  = e;
    return r;
  endfunction

  // drive one item at falling edges, optional idle gap first
  task automatic send_item(input stim_row_t row);
    int gap;
    bit taken;
    gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 3) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.word         <= row.word;
    in_ch.packet_start <= row.sop;
    in_ch.packet_end   <= row.eop;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = (in_ch.ready === 1'b1);
      @(negedge clk);
    end
    assemble_word(row);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (words_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic load_settings(input logic [31:0] marker_v, input logic [31:0] type_v,
                               input logic [31:0] id_v, input logic [31:0] size_v);
    cfg_we    <= 1'b1;
    cfg_index <= pfa_pkg::REG_END_MARKER;
    cfg_data  <= marker_v;
    @(negedge clk);
    cfg_index <= pfa_pkg::REG_EQUIPMENT_TYPE;
    cfg_data  <= type_v;
    @(negedge clk);
    cfg_index <= pfa_pkg::REG_EQUIPMENT_ID;
    cfg_data  <= id_v;
    @(negedge clk);
    cfg_index <= pfa_pkg::REG_ELEMENT_SIZE;
    cfg_data  <= size_v;
    @(negedge clk);
    cfg_we <= 1'b0;
    close_word = marker_v;
    type_word  = type_v;
    id_word    = id_v;
    elem_word  = size_v;
  endtask

  // one event: mostly in-order packets with random payload, some noise, then usually a close
  task automatic gen_event(input bit big_ok);
    int n_pkts;
    int len;
    int p;
    int k;
    logic [31:0] w;
    bit big;
    big    = big_ok && ($urandom_range(3) == 0);
    n_pkts = big ? $urandom_range(3, 4) : $urandom_range(0, 3);
    for (p = 0; p < n_pkts; p++) begin
      len = big ? $urandom_range(9, 14) : $urandom_range(2, 5);
      w = ($urandom_range(9) == 0) ? $urandom : seq_count;
      send_item(mk_row(w, 1'b1, 1'b0));
      for (k = 1; k < len; k++)
        send_item(mk_row($urandom, 1'b0, k == len - 1));
      if ($urandom_range(5) == 0) begin
        case ($urandom_range(2))
          0: send_item(mk_row($urandom, 1'b0, 1'($urandom_range(1))));
          1: begin
            w = $urandom;
            if (w == close_word) w = ~w;
            send_item(mk_row(w, 1'b1, 1'b1));
          end
          default: begin
            // packet cut short, next one starts without an end mark
            send_item(mk_row(seq_count, 1'b1, 1'b0));
            send_item(mk_row($urandom, 1'b0, 1'b0));
          end
        endcase
      end
    end
    // now and then let words carry over into the next event
    if (big || fill_count >= 12 || $urandom_range(9) != 0)
      send_item(mk_row(close_word, 1'b1, 1'b1));
  endtask

  // result checker
  always @(posedge clk) begin
    event_word_t want;
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (words_due.size() == 0) begin
        report_mismatch($sformatf("event word %h with nothing pending",
                                  out_ch.out_word));
      end else begin
        want = words_due.pop_front();
        check_field("out_word", out_ch.out_word, want.out_word);
        check_field("event_number", out_ch.event_number, want.event_number);
        check_field("equipment_tag", out_ch.equipment_tag, want.equipment_tag);
        check_field("sequence_error", {31'b0, out_ch.sequence_error}, {31'b0, want.seq_err});
        check_field("overflowed", {31'b0, out_ch.overflowed}, {31'b0, want.ovf});
        check_field("last_of_event", {31'b0, out_ch.last_of_event}, {31'b0, want.last});
      end
      words_checked++;
    end
  end

  // main sequence
  initial begin
    int r;
    int ph;
    int phase_end;
    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_index          <= pfa_pkg::REG_END_MARKER;
    cfg_data           <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.word         <= '0;
    in_ch.packet_start <= 1'b0;
    in_ch.packet_end   <= 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (r = 0; r < DIR_ROWS; r++)
      send_item(directed_rows[r]);

    // random phases: settings and idle pattern change between them
    for (ph = 0; ph < 4; ph++) begin
      wait_drained();
      case (ph)
        0: begin
          load_settings('0, '0, '0, '0);
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          load_settings('1, '1, '1, '1);
          send_idle_pct  = 59;
          recv_stall_pct = 0;
        end
        2: begin
          load_settings($urandom, $urandom, $urandom, $urandom);
          send_idle_pct  = 0;
          recv_stall_pct = 59;
        end
        default: begin
          load_settings(pfa_pkg::RST_END_MARKER, $urandom, $urandom, $urandom);
          send_idle_pct  = 38;
          recv_stall_pct = 38;
        end
      endcase
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end)
        gen_event(ph == 3);
    end
    wait_drained();

    $display("Sent %0d packet words, closed %0d events, checked %0d event words",
             items_sent, event_count, words_checked);
    $display("Covered four register settings, store overflow and four idle patterns");
    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
